FILE: rtl/tsb_pkg.sv
// Shared constants and types of the bilinear texture sampler.
package tsb_pkg;

  localparam int MAX_TEXELS_DEF = 65536;
  localparam int MAX_DIM_DEF    = 256;
  localparam int FRAC_BITS      = 12;
  localparam int TEXEL_BITS     = 24;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 9;
  localparam int LANES          = 4;

  typedef logic [TEXEL_BITS-1:0] texel_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TEX_WIDTH       = 3'd0,
    REG_TEX_HEIGHT      = 3'd1,
    REG_REPEAT_WRAP     = 3'd2,
    REG_FILTER_BILINEAR = 3'd3,
    REG_CLAMP_MAX       = 3'd4
  } cfg_reg_t;

endpackage

FILE: rtl/tsb_ram.sv
// Generic single-port RAM with registered read.
module tsb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/texture_sampler_bilinear.sv
// Top level of the bilinear texture sampler: nine-stage pipeline over four texel RAM copies.
//
// Items enter on start while busy is low, one per cycle. mode 0 writes texel_rgb at
// texel_addr; mode 1 samples the texture from three vertex UV pairs and two weights.
// A sample shows red, green and blue with result_valid high for one cycle as it
// leaves the last stage. A write gives no result.
// Sustained rate is one item per clock; the four neighbour texels come from four
// copies of the texel store, each with its own read port, so no fetch waits.
// Writes travel down the pipeline and update all copies at the read stage, so every
// item sees exactly the writes accepted before it.
// Configuration is written on cfg_valid (cfg_ready is always high) with cfg_index and
// cfg_data. The user must write only with no item in flight; the block does not check.
// rst (synchronous) empties the pipeline and loads register defaults; busy is high
// during reset. The texel store is not cleared. The receiver cannot stall.
module texture_sampler_bilinear #(
  parameter int MAX_TEXELS = tsb_pkg::MAX_TEXELS_DEF,
  parameter int MAX_DIM    = tsb_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               mode,
  input  logic [15:0]                        texel_addr,
  input  logic [23:0]                        texel_rgb,
  input  logic signed [15:0]                 vertex_a_u,
  input  logic signed [15:0]                 vertex_a_v,
  input  logic signed [15:0]                 vertex_b_u,
  input  logic signed [15:0]                 vertex_b_v,
  input  logic signed [15:0]                 vertex_c_u,
  input  logic signed [15:0]                 vertex_c_v,
  input  logic [15:0]                        weight_beta,
  input  logic [15:0]                        weight_gamma,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tsb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tsb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                               result_valid,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue
);
  import tsb_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int IW = $clog2(MAX_DIM);
  localparam int TA = $clog2(MAX_TEXELS);
  localparam int QW = 21;
  localparam int PW = QW + DW + 1;
  localparam int AW = IW + DW + 1;
  localparam int WW = 2 * FRAC_BITS + 1;
  localparam int MW = WW + 8;
  localparam int SW = MW + 2;

  logic [8:0] tex_width;
  logic [8:0] tex_height;
  logic       repeat_wrap;
  logic       filter_bilinear;
  logic [7:0] clamp_max;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width       <= 9'd256;
      tex_height      <= 9'd256;
      repeat_wrap     <= 1'b0;
      filter_bilinear <= 1'b1;
      clamp_max       <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:       tex_width       <= cfg_data;
        REG_TEX_HEIGHT:      tex_height      <= cfg_data;
        REG_REPEAT_WRAP:     repeat_wrap     <= cfg_data[0];
        REG_FILTER_BILINEAR: filter_bilinear <= cfg_data[0];
        REG_CLAMP_MAX:       clamp_max       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;

  always_comb begin
    if (tex_width == '0) w_eff = DW'(1);
    else if (32'(tex_width) > MAX_DIM) w_eff = DW'(MAX_DIM);
    else w_eff = DW'(tex_width);
    if (tex_height == '0) h_eff = DW'(1);
    else if (32'(tex_height) > MAX_DIM) h_eff = DW'(MAX_DIM);
    else h_eff = DW'(tex_height);
  end

  function automatic logic [IW-1:0] edge_clamp(input logic signed [PW:0] x,
                                               input logic [DW-1:0] dim);
    logic signed [PW:0] hi;
    hi = $signed((PW+1)'(dim)) - $signed((PW+1)'(1));
    if (x < 0) return '0;
    else if (x > hi) return IW'(hi);
    else return IW'(x);
  endfunction

  logic accept;
  assign accept = start && !busy;

  // valid and mode travel with each stage
  logic [8:1] v;
  logic [8:1] m;
  logic [15:0] wa [1:6];
  texel_t      wd [1:6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[7:1], accept};
    end
  end

  always_ff @(posedge clk) begin
    m  <= {m[7:1], mode};
    wa[1] <= texel_addr;
    wd[1] <= texel_rgb;
    for (int s = 2; s <= 6; s++) begin
      wa[s] <= wa[s-1];
      wd[s] <= wd[s-1];
    end
  end

  // stage 1: differences
  logic signed [15:0] au1, av1;
  logic signed [16:0] dbu1, dcu1, dbv1, dcv1;
  logic [15:0]        wb1, wg1;

  always_ff @(posedge clk) begin
    au1  <= vertex_a_u;
    av1  <= vertex_a_v;
    dbu1 <= 17'(vertex_b_u) - 17'(vertex_a_u);
    dcu1 <= 17'(vertex_c_u) - 17'(vertex_a_u);
    dbv1 <= 17'(vertex_b_v) - 17'(vertex_a_v);
    dcv1 <= 17'(vertex_c_v) - 17'(vertex_a_v);
    wb1  <= weight_beta;
    wg1  <= weight_gamma;
  end

  // stage 2: weight products
  logic signed [15:0] au2, av2;
  logic signed [33:0] pbu2, pgu2, pbv2, pgv2;

  always_ff @(posedge clk) begin
    au2  <= au1;
    av2  <= av1;
    pbu2 <= $signed({1'b0, wb1}) * dbu1;
    pgu2 <= $signed({1'b0, wg1}) * dcu1;
    pbv2 <= $signed({1'b0, wb1}) * dbv1;
    pgv2 <= $signed({1'b0, wg1}) * dcv1;
  end

  // stage 3: sum, round to Q.12, optional wrap
  logic signed [35:0] q27u, q27v, qru, qrv;
  logic signed [QW-1:0] qu3, qv3;

  always_comb begin
    q27u = (36'(au2) <<< 15) + 36'(pbu2) + 36'(pgu2);
    q27v = (36'(av2) <<< 15) + 36'(pbv2) + 36'(pgv2);
    qru  = (q27u + 36'sd16384) >>> 15;
    qrv  = (q27v + 36'sd16384) >>> 15;
  end

  always_ff @(posedge clk) begin
    qu3 <= repeat_wrap ? $signed(QW'(qru[FRAC_BITS-1:0])) : qru[QW-1:0];
    qv3 <= repeat_wrap ? $signed(QW'(qrv[FRAC_BITS-1:0])) : qrv[QW-1:0];
  end

  // stage 4: scale by texture size
  logic signed [PW-1:0] pu4, pv4;

  always_ff @(posedge clk) begin
    pu4 <= qu3 * $signed({1'b0, w_eff});
    pv4 <= qv3 * $signed({1'b0, h_eff});
  end

  // stage 5: texel indices and fractions
  logic signed [PW:0]   nu, nv, fu, fv;
  logic [IW-1:0]        i0_5, i1_5, j0_5, j1_5;
  logic [FRAC_BITS-1:0] dx5, dy5;

  always_comb begin
    nu = ((PW+1)'(pu4) + (PW+1)'(2048)) >>> FRAC_BITS;
    nv = ((PW+1)'(pv4) + (PW+1)'(2048)) >>> FRAC_BITS;
    fu = (PW+1)'(pu4) >>> FRAC_BITS;
    fv = (PW+1)'(pv4) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (filter_bilinear) begin
      i0_5 <= edge_clamp(fu, w_eff);
      i1_5 <= edge_clamp(fu + (PW+1)'(1), w_eff);
      j0_5 <= edge_clamp(fv, h_eff);
      j1_5 <= edge_clamp(fv + (PW+1)'(1), h_eff);
      dx5  <= pu4[FRAC_BITS-1:0];
      dy5  <= pv4[FRAC_BITS-1:0];
    end else begin
      i0_5 <= edge_clamp(nu, w_eff);
      i1_5 <= edge_clamp(nu, w_eff);
      j0_5 <= edge_clamp(nv, h_eff);
      j1_5 <= edge_clamp(nv, h_eff);
      dx5  <= '0;
      dy5  <= '0;
    end
  end

  // stage 6: linear addresses and blend weights; RAM access
  logic [AW-1:0]        la [LANES];
  logic [FRAC_BITS:0]   ex5, ey5, dxe5, dye5;
  logic [TA-1:0]        addr6 [LANES];
  logic [LANES-1:0]     inr6;
  logic [WW-1:0]        wt6 [LANES];

  always_comb begin
    la[0] = AW'(j0_5) * AW'(w_eff) + AW'(i0_5);
    la[1] = AW'(j0_5) * AW'(w_eff) + AW'(i1_5);
    la[2] = AW'(j1_5) * AW'(w_eff) + AW'(i0_5);
    la[3] = AW'(j1_5) * AW'(w_eff) + AW'(i1_5);
    dxe5  = (FRAC_BITS+1)'(dx5);
    dye5  = (FRAC_BITS+1)'(dy5);
    ex5   = (FRAC_BITS+1)'(1 << FRAC_BITS) - dxe5;
    ey5   = (FRAC_BITS+1)'(1 << FRAC_BITS) - dye5;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      addr6[k] <= TA'(la[k]);
      inr6[k]  <= 64'(la[k]) < 64'(MAX_TEXELS);
    end
    wt6[0] <= WW'(ex5) * WW'(ey5);
    wt6[1] <= WW'(dxe5) * WW'(ey5);
    wt6[2] <= WW'(ex5) * WW'(dye5);
    wt6[3] <= WW'(dxe5) * WW'(dye5);
  end

  logic   wr_en;
  texel_t rd7 [LANES];

  assign wr_en = v[6] && !m[6] && (64'(wa[6]) < 64'(MAX_TEXELS));

  for (genvar k = 0; k < LANES; k++) begin : g_bank
    tsb_ram #(
      .WIDTH(TEXEL_BITS),
      .DEPTH(MAX_TEXELS)
    ) u_ram (
      .clk  (clk),
      .we   (wr_en),
      .addr (wr_en ? TA'(wa[6]) : addr6[k]),
      .wdata(wd[6]),
      .rdata(rd7[k])
    );
  end

  // stage 7: texel data arrives
  logic [LANES-1:0] inr7;
  logic [WW-1:0]    wt7 [LANES];

  always_ff @(posedge clk) begin
    inr7 <= inr6;
    for (int k = 0; k < LANES; k++) wt7[k] <= wt6[k];
  end

  // stage 8: channel products
  logic [MW-1:0] pr8 [LANES][3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      for (int c = 0; c < 3; c++) begin
        pr8[k][c] <= inr7[k] ? MW'(rd7[k][16-8*c +: 8]) * MW'(wt7[k]) : '0;
      end
    end
  end

  // stage 9: sum, round, clamp
  logic [SW-1:0] sum9 [3];
  logic [7:0]    ch9  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum9[c] = SW'(pr8[0][c]) + SW'(pr8[1][c]) + SW'(pr8[2][c]) + SW'(pr8[3][c])
              + SW'(1 << (2*FRAC_BITS-1));
      ch9[c]  = sum9[c][2*FRAC_BITS +: 8];
      if (ch9[c] > clamp_max) ch9[c] = clamp_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= v[8] && m[8];
    end
  end

  always_ff @(posedge clk) begin
    red   <= ch9[0];
    green <= ch9[1];
    blue  <= ch9[2];
  end

endmodule

FILE: rtl/tsb_checker.sv
// Port-level checks of the texture sampler, bound to the top level.
module tsb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic mode,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic result_valid
);

  a_sample_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode) |-> ##9 result_valid)
    else $error("sample item gave no result");

  a_write_gives_none: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !mode) |-> ##9 !result_valid)
    else $error("write item gave a result");

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && mode, 9))
    else $error("result without a sample item");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind texture_sampler_bilinear tsb_checker u_tsb_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .mode        (mode),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready),
  .result_valid(result_valid)
);

FILE: bench/tb_top.sv
// Self-checking bench of texture_sampler_bilinear: directed table, then random phases.
module tb_top;
  import tsb_pkg::*;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] addr;
    logic [23:0] rgb;
    logic [15:0] au, av, bu, bv, cu, cv;
    logic [15:0] wb, wg;
  } item_t;

  typedef struct packed {
    item_t it;
    logic  known;
    rgb_t  want;
  } row_t;

  logic clk = 0, rst = 1, start = 0, mode = 0, cfg_valid = 0;
  logic [15:0] texel_addr = 0, weight_beta = 0, weight_gamma = 0;
  logic [23:0] texel_rgb = 0;
  logic signed [15:0] vertex_a_u = 0, vertex_a_v = 0, vertex_b_u = 0;
  logic signed [15:0] vertex_b_v = 0, vertex_c_u = 0, vertex_c_v = 0;
  logic [CFG_IDX_BITS-1:0] cfg_index = 0;
  logic [CFG_DATA_BITS-1:0] cfg_data = 0;
  logic busy, cfg_ready, result_valid;
  logic [7:0] red, green, blue;

  texture_sampler_bilinear u_top (.*);

  initial forever #5 clk = ~clk;

  // predictor state
  logic [23:0] tex_mem [0:65535];
  bit          written [0:65535];
  logic [8:0]  m_width, m_height;
  logic        m_wrap, m_bilin;
  logic [7:0]  m_clamp;
  rgb_t        colour_q [$];
  int          errors = 0;
  longint      cycles = 0;
  bit          gaps_on = 1;
  int          sent = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("** texture_sampler_bilinear: FAILED **");
      $finish;
    end
  end

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (colour_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        rgb_t e;
        e = colour_q.pop_front();
        if (red !== e.r) report($sformatf("red %0h want %0h", red, e.r));
        if (green !== e.g) report($sformatf("green %0h want %0h", green, e.g));
        if (blue !== e.b) report($sformatf("blue %0h want %0h", blue, e.b));
      end
    end
  end

  function automatic longint eff_dim(logic [8:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return longint'(d);
  endfunction

  function automatic longint clampi(longint x, longint hi);
    if (x < 0) return 0;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic longint coord(logic signed [15:0] a, logic signed [15:0] b,
                                   logic signed [15:0] c, logic [15:0] wb, logic [15:0] wg);
    longint ai, bi, ci, q;
    ai = longint'(a); bi = longint'(b); ci = longint'(c);
    q = ai * 32768 + longint'(wb) * (bi - ai) + longint'(wg) * (ci - ai);
    q = (q + 16384) >>> 15;
    if (m_wrap) q = q & 64'hFFF;
    return q;
  endfunction

  // texel addresses a sample reads: n entries of adr
  function automatic void sample_addrs(item_t it, output int adr[4], output int n);
    longint w, h, pu, pv, p, q;
    w = eff_dim(m_width);
    h = eff_dim(m_height);
    pu = coord(it.au, it.bu, it.cu, it.wb, it.wg) * w;
    pv = coord(it.av, it.bv, it.cv, it.wb, it.wg) * h;
    if (!m_bilin) begin
      n = 1;
      adr[0] = int'(clampi((pv + 2048) >>> 12, h - 1) * w + clampi((pu + 2048) >>> 12, w - 1));
    end else begin
      p = pu >>> 12;
      q = pv >>> 12;
      n = 4;
      adr[0] = int'(clampi(q, h - 1) * w + clampi(p, w - 1));
      adr[1] = int'(clampi(q, h - 1) * w + clampi(p + 1, w - 1));
      adr[2] = int'(clampi(q + 1, h - 1) * w + clampi(p, w - 1));
      adr[3] = int'(clampi(q + 1, h - 1) * w + clampi(p + 1, w - 1));
    end
  endfunction

  function automatic rgb_t predict_colour(item_t it);
    longint w, h, pu, pv, dx, dy, ex, ey, s, ch;
    int adr[4], n;
    longint res[3];
    rgb_t o;
    w = eff_dim(m_width);
    h = eff_dim(m_height);
    pu = coord(it.au, it.bu, it.cu, it.wb, it.wg) * w;
    pv = coord(it.av, it.bv, it.cv, it.wb, it.wg) * h;
    sample_addrs(it, adr, n);
    dx = pu & 64'hFFF; dy = pv & 64'hFFF;
    ex = 4096 - dx; ey = 4096 - dy;
    for (int c = 0; c < 3; c++) begin
      if (!m_bilin) begin
        res[c] = (tex_mem[adr[0]] >> (16 - 8 * c)) & 8'hFF;
      end else begin
        s = 0;
        ch = (tex_mem[adr[0]] >> (16 - 8 * c)) & 8'hFF; s += ch * ex * ey;
        ch = (tex_mem[adr[1]] >> (16 - 8 * c)) & 8'hFF; s += ch * dx * ey;
        ch = (tex_mem[adr[2]] >> (16 - 8 * c)) & 8'hFF; s += ch * ex * dy;
        ch = (tex_mem[adr[3]] >> (16 - 8 * c)) & 8'hFF; s += ch * dx * dy;
        res[c] = (s + (1 << 23)) >>> 24;
      end
      if (res[c] > longint'(m_clamp)) res[c] = longint'(m_clamp);
    end
    o.r = 8'(res[0]); o.g = 8'(res[1]); o.b = 8'(res[2]);
    return o;
  endfunction

  // drive one item and wait until it is taken; start stays high between back-to-back items
  task automatic drive_item(item_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    mode <= it.mode; texel_addr <= it.addr; texel_rgb <= it.rgb;
    vertex_a_u <= it.au; vertex_a_v <= it.av; vertex_b_u <= it.bu;
    vertex_b_v <= it.bv; vertex_c_u <= it.cu; vertex_c_v <= it.cv;
    weight_beta <= it.wb; weight_gamma <= it.wg;
    start <= 1;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic write_texel(logic [15:0] a, logic [23:0] v);
    item_t it;
    it = '0;
    it.mode = 1'b0; it.addr = a; it.rgb = v;
    it.au = 16'($urandom); it.bv = 16'($urandom); it.wg = 16'($urandom);
    drive_item(it);
    tex_mem[a] = v;
    written[a] = 1;
  endtask

  // sample item; any texel it would read that holds nothing yet is written first
  task automatic sample(item_t it, bit known, rgb_t want);
    int adr[4], n;
    it.mode = 1'b1;
    sample_addrs(it, adr, n);
    for (int k = 0; k < n; k++)
      if (!written[adr[k]]) write_texel(16'(adr[k]), 24'($urandom));
    if (!known) want = predict_colour(it);
    drive_item(it);
    colour_q.push_back(want);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [8:0] d);
    start <= 0;
    wait (colour_q.size() == 0);
    repeat (14) @(posedge clk);
    cfg_index <= idx; cfg_data <= d; cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_TEX_WIDTH:       m_width = d;
      REG_TEX_HEIGHT:      m_height = d;
      REG_REPEAT_WRAP:     m_wrap = d[0];
      REG_FILTER_BILINEAR: m_bilin = d[0];
      REG_CLAMP_MAX:       m_clamp = d[7:0];
      default: ;
    endcase
  endtask

  function automatic item_t rand_item();
    item_t it;
    int sel;
    it = '0;
    it.mode = ($urandom_range(0, 3) != 0);
    it.addr = 16'($urandom); it.rgb = 24'($urandom);
    sel = $urandom_range(0, 3);
    it.au = (sel == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 12288)) - 4096);
    it.av = (sel == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 12288)) - 4096);
    it.bu = (sel == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 12288)) - 4096);
    it.bv = (sel == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 12288)) - 4096);
    it.cu = (sel == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 12288)) - 4096);
    it.cv = (sel == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 12288)) - 4096);
    if (sel == 1) begin
      it.wb = 16'($urandom); it.wg = 16'($urandom);
    end else begin
      it.wb = 16'($urandom_range(0, 32768));
      it.wg = 16'($urandom_range(0, 32768 - int'(it.wb)));
    end
    return it;
  endfunction

  row_t table_rows [13];

  initial begin
    item_t it;
    rgb_t none;
    int base, k;
    none = '0;
    m_width = 9'd256; m_height = 9'd256; m_wrap = 1'b0; m_bilin = 1'b1; m_clamp = 8'd255;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table
    table_rows[0]  = '{'{0, 16'h0000, 24'h123456, 0,0,0,0,0,0, 0,0}, 0, none};
    table_rows[1]  = '{'{0, 16'hFFFF, 24'hABCDEF, 0,0,0,0,0,0, 0,0}, 0, none};
    table_rows[2]  = '{'{1, 0, 0, 0,0,0,0,0,0, 0,0}, 1, 24'h123456};
    table_rows[3]  = '{'{1, 0, 0, 16'h8000,16'h8000,16'h8000,16'h8000,16'h8000,16'h8000,
                         0,0}, 1, 24'h123456};
    table_rows[4]  = '{'{1, 0, 0, 16'h7FFF,16'h7FFF,16'h7FFF,16'h7FFF,16'h7FFF,16'h7FFF,
                         0,0}, 1, 24'hABCDEF};
    table_rows[5]  = '{'{1, 0, 0, 16'h7FFF,16'h7FFF,16'h7FFF,16'h7FFF,16'h7FFF,16'h7FFF,
                         16'h8000,16'h8000}, 1, 24'hABCDEF};
    table_rows[6]  = '{'{1, 0, 0, 0,0,16'h1000,16'h1000,0,0, 16'h8000,0}, 1, 24'hABCDEF};
    table_rows[7]  = '{'{1, 0, 0, 0,0,16'h0800,16'h0400,16'h0C00,16'h0200,
                         16'h4000,16'h2000}, 0, none};
    table_rows[8]  = '{'{1, 0, 0, 16'h0123,16'h0456,16'h0FFF,16'h0001,16'h0800,16'h0777,
                         16'hFFFF,16'hFFFF}, 0, none};
    table_rows[9]  = '{'{0, 16'h8001, 24'hFFFFFF, 0,0,0,0,0,0, 0,0}, 0, none};
    table_rows[10] = '{'{0, 16'h7FFE, 24'h000000, 0,0,0,0,0,0, 0,0}, 0, none};
    table_rows[11] = '{'{1, 0, 0, 16'h0001,16'h0FFF,16'h0003,16'h0F00,16'h0005,16'h0A00,
                         16'h7FFF,16'h0001}, 0, none};
    table_rows[12] = '{'{1, 0, 0, 16'hF000,16'h1800,16'h2000,16'hE000,16'h0400,16'h0400,
                         16'h1234,16'h4321}, 0, none};
    foreach (table_rows[r]) begin
      if (table_rows[r].it.mode) sample(table_rows[r].it, table_rows[r].known,
                                        table_rows[r].want);
      else write_texel(table_rows[r].it.addr, table_rows[r].it.rgb);
    end

    // random phases over register settings, extremes first; each phase drives about 60 items
    for (int ph = 0; ph < 10; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: begin write_reg(REG_TEX_WIDTH, 9'd1); write_reg(REG_TEX_HEIGHT, 9'd1); end
          2: begin write_reg(REG_TEX_WIDTH, 9'd0); write_reg(REG_TEX_HEIGHT, 9'h1FF); end
          3: begin write_reg(REG_TEX_WIDTH, 9'd256); write_reg(REG_TEX_HEIGHT, 9'd0); end
          default: begin
            write_reg(REG_TEX_WIDTH, 9'($urandom));
            write_reg(REG_TEX_HEIGHT, 9'($urandom_range(1, 300)));
          end
        endcase
        write_reg(REG_REPEAT_WRAP, 9'($urandom));
        write_reg(REG_FILTER_BILINEAR, (ph == 4) ? 9'd0 : 9'($urandom));
        write_reg(REG_CLAMP_MAX, (ph == 5) ? 9'd0 : (ph == 6) ? 9'h1FF : 9'($urandom));
      end
      gaps_on = (ph % 3 != 2);
      base = sent;
      k = 0;
      while (sent - base < 60) begin
        if (ph == 7 && k == 5) begin
          start <= 0;
          wait (colour_q.size() == 0);
          @(posedge clk);
        end
        it = rand_item();
        if (it.mode) sample(it, 0, none);
        else write_texel(it.addr, it.rgb);
        k++;
      end
    end
    start <= 0;

    wait (colour_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && colour_q.size() == 0) begin
      $display("** texture_sampler_bilinear: PASSED **");
    end else begin
      $display("** texture_sampler_bilinear: FAILED **");
    end
    $finish;
  end

endmodule
